>>> src/morton_neighbor_generator_top_assert.svh
// Assertion macros for the Morton neighbourhood generator.
// Used by morton_neighbor_generator_top; depends on nothing else.
`ifndef MORTON_NEIGHBOR_GENERATOR_TOP_ASSERT_SVH
`define MORTON_NEIGHBOR_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MNG_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MNG_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error(msg);

`endif

>>> src/mng_pkg.sv
// Shared widths and constants for the Morton neighbourhood generator.
// Depends on nothing; used by morton_neighbor_generator_top.
package mng_pkg;

	localparam int BATCH_W     = 7;
	localparam int GROUP_W     = 21;
	localparam int SLOT_W      = 6;
	localparam int INDEX_W     = 32;
	localparam int DEPTH_CFG_W = 4;
	localparam int APB_ADDR_W  = 2;
	localparam int APB_DATA_W  = 32;

	localparam logic [APB_ADDR_W-1:0]  TREE_DEPTH_ADDR    = '0;
	localparam logic [SLOT_W-1:0]      LAST_SLOT          = '1;
	localparam logic [DEPTH_CFG_W-1:0] TREE_DEPTH_RESET   = 4'd1;
	localparam logic [INDEX_W-1:0]     OUTSIDE_GRID_INDEX = '1;

endpackage

>>> src/morton_neighbor_generator_top.sv
// Morton-code octree neighbourhood generator, top level.
// Depends on mng_pkg and morton_neighbor_generator_top_assert.svh.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------
//  item     | item_valid / item_stall     | batch_index[6:0], group_index[20:0]
//  result   | result_valid / result_stall | slot[5:0], neighbor_index[31:0], last
//  config   | psel/penable/pwrite, pready | paddr[1:0], pwdata/prdata[31:0]
//
// Every item yields 64 result transfers, one per cycle unless result_stall holds the
// pipeline; the slot generator takes no new item before it is through with the last.
// A new item is taken in the cycle that the previous item's last slot is issued, so
// results stream without a gap. After the item's transfer, its first result passes
// the slot generator, stage 1 and stage 2 and is presented from the stage 3 register.
// Reset clears the valid bits and the generator; tree_depth returns to one.
// A result stall freezes the whole pipeline, so nothing is lost or repeated.
module morton_neighbor_generator_top #(
	parameter int MAX_DEPTH = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Item channel.
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic [mng_pkg::BATCH_W-1:0]          batch_index,
	input  logic [mng_pkg::GROUP_W-1:0]          group_index,
	// Result channel.
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [mng_pkg::SLOT_W-1:0]           slot,
	output logic signed [mng_pkg::INDEX_W-1:0]   neighbor_index,
	output logic                                 last,
	// Configuration port.
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [mng_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [mng_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [mng_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                 pready
);

	`include "morton_neighbor_generator_top_assert.svh"

	// Width of an effective depth value, of a coordinate with guard bits for the
	// offset arithmetic, of an interleaved key and of a shift by three times depth.
	localparam int DW  = $clog2(MAX_DEPTH + 1);
	localparam int CW  = MAX_DEPTH + 2;
	localparam int KW  = 3 * MAX_DEPTH;
	localparam int SHW = $clog2(3 * MAX_DEPTH + 1);
	localparam int GX  = (KW > mng_pkg::GROUP_W) ? KW : mng_pkg::GROUP_W;

	// ------------------------------------------------------------------
	// Configuration register. The single register sits at address zero;
	// writes elsewhere are ignored and only the low four bits are kept.
	// ------------------------------------------------------------------
	logic [mng_pkg::DEPTH_CFG_W-1:0] tree_depth_q;

	assign pready = 1'b1;
	assign prdata = {{(mng_pkg::APB_DATA_W-mng_pkg::DEPTH_CFG_W){1'b0}}, tree_depth_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tree_depth_q <= mng_pkg::TREE_DEPTH_RESET;
		end else if (psel && penable && pwrite && pready
				&& (paddr == mng_pkg::TREE_DEPTH_ADDR)) begin
			tree_depth_q <= pwdata[mng_pkg::DEPTH_CFG_W-1:0];
		end
	end

	// A depth of zero behaves as one and anything above MAX_DEPTH is clamped.
	logic [DW-1:0] eff_depth;

	always_comb begin
		if (tree_depth_q == '0) begin
			eff_depth = DW'(1);
		end else if (int'(tree_depth_q) > MAX_DEPTH) begin
			eff_depth = DW'(MAX_DEPTH);
		end else begin
			eff_depth = DW'(tree_depth_q);
		end
	end

	// ------------------------------------------------------------------
	// Pipeline enable: everything moves unless a finished result is held
	// back by the consumer.
	// ------------------------------------------------------------------
	logic en;
	logic item_take;

	assign en = !(result_valid && result_stall);

	// ------------------------------------------------------------------
	// Slot generator. It holds the group's base coordinates and issues one
	// slot per enabled cycle.
	// ------------------------------------------------------------------
	logic                         gen_busy_q;
	logic [mng_pkg::SLOT_W-1:0]   slot_q;
	logic [MAX_DEPTH-1:0]         base_x_q, base_y_q, base_z_q;
	logic [mng_pkg::BATCH_W-1:0]  batch_q;
	logic [DW-1:0]                depth_q;
	logic                         gen_fire;
	logic                         gen_done;
	logic [GX-1:0]                group_ext;
	logic [MAX_DEPTH-1:0]         new_x, new_y, new_z;

	assign gen_fire   = gen_busy_q && en;
	assign gen_done   = gen_fire && (slot_q == mng_pkg::LAST_SLOT);
	assign item_stall = !en || (gen_busy_q && (slot_q != mng_pkg::LAST_SLOT));
	assign item_take  = item_valid && !item_stall;
	assign group_ext  = GX'(group_index);

	// De-interleave the group key: every third bit per axis, x highest. The
	// group is the first child, so coordinate bit zero is always clear.
	always_comb begin
		new_x = '0;
		new_y = '0;
		new_z = '0;
		for (int k = 0; k < MAX_DEPTH - 1; k++) begin
			if (k + 1 < int'(eff_depth)) begin
				new_x[k+1] = group_ext[3*k+2];
				new_y[k+1] = group_ext[3*k+1];
				new_z[k+1] = group_ext[3*k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_busy_q <= 1'b0;
			slot_q     <= '0;
		end else if (item_take) begin
			gen_busy_q <= 1'b1;
			slot_q     <= '0;
		end else if (gen_fire) begin
			gen_busy_q <= !gen_done;
			slot_q     <= slot_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			base_x_q <= new_x;
			base_y_q <= new_y;
			base_z_q <= new_z;
			batch_q  <= batch_index;
			depth_q  <= eff_depth;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: apply the offsets and check the neighbour against the grid.
	// ------------------------------------------------------------------
	logic                        valid_s1;
	logic [mng_pkg::SLOT_W-1:0]  slot_s1;
	logic [MAX_DEPTH-1:0]        x_s1, y_s1, z_s1;
	logic                        in_grid_s1;
	logic [mng_pkg::BATCH_W-1:0] batch_s1;
	logic [DW-1:0]               depth_s1;
	logic [CW-1:0]               nx, ny, nz, side;

	// Offsets run -1..+2; below zero the guard bits turn the value large.
	assign nx   = {2'b00, base_x_q} + CW'(slot_q[5:4]) - CW'(1);
	assign ny   = {2'b00, base_y_q} + CW'(slot_q[3:2]) - CW'(1);
	assign nz   = {2'b00, base_z_q} + CW'(slot_q[1:0]) - CW'(1);
	assign side = CW'(1) << depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= gen_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slot_s1    <= slot_q;
			x_s1       <= nx[MAX_DEPTH-1:0];
			y_s1       <= ny[MAX_DEPTH-1:0];
			z_s1       <= nz[MAX_DEPTH-1:0];
			in_grid_s1 <= (nx < side) && (ny < side) && (nz < side);
			batch_s1   <= batch_q;
			depth_s1   <= depth_q;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: re-interleave the key and form the batch offset.
	// ------------------------------------------------------------------
	logic                         valid_s2;
	logic [mng_pkg::SLOT_W-1:0]   slot_s2;
	logic                         in_grid_s2;
	logic [KW-1:0]                key_s2;
	logic [mng_pkg::INDEX_W-1:0]  offset_s2;
	logic [KW-1:0]                key;
	logic [SHW-1:0]               shift;

	// Coordinates inside the grid have no bits at or above depth, so a plain
	// interleave of every bit gives the key.
	always_comb begin
		key = '0;
		for (int d = 0; d < MAX_DEPTH; d++) begin
			key[3*d+2] = x_s1[d];
			key[3*d+1] = y_s1[d];
			key[3*d]   = z_s1[d];
		end
	end

	assign shift = SHW'(depth_s1) * SHW'(3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slot_s2    <= slot_s1;
			in_grid_s2 <= in_grid_s1;
			key_s2     <= key;
			offset_s2  <= mng_pkg::INDEX_W'(batch_s1) << shift;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: add the batch offset; this is the output register.
	// ------------------------------------------------------------------
	logic                        valid_s3;
	logic [mng_pkg::SLOT_W-1:0]  slot_s3;
	logic [mng_pkg::INDEX_W-1:0] index_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slot_s3  <= slot_s2;
			index_s3 <= in_grid_s2 ? (mng_pkg::INDEX_W'(key_s2) + offset_s2)
			                       : mng_pkg::OUTSIDE_GRID_INDEX;
		end
	end

	assign result_valid   = valid_s3;
	assign slot           = slot_s3;
	assign neighbor_index = signed'(index_s3);
	assign last           = (slot_s3 == mng_pkg::LAST_SLOT);

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`MNG_ASSERT_NEXT(a_take_starts_walk, clk, arst_n, item_take,
		gen_busy_q && (slot_q == '0), "accepted item did not start at slot zero")
	`MNG_ASSERT_NOW(a_take_only_at_end, clk, arst_n, item_take,
		!gen_busy_q || gen_done, "item accepted while a walk was still running")
	`MNG_ASSERT_NEXT(a_walk_ends, clk, arst_n, gen_done && !item_take,
		!gen_busy_q, "generator stayed busy after the last slot")
	`MNG_ASSERT_NEXT(a_stage_moves, clk, arst_n, valid_s2 && en,
		valid_s3, "a result was lost between stage two and the output")

endmodule
